### sv/mvn_pkg.sv
package mvn_pkg;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_TRI   = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	localparam logic KIND_FACE   = 1'b0;
	localparam logic KIND_VERTEX = 1'b1;

	localparam int IDX_IN_W = 10;
	localparam int POS_W    = 16;
	localparam int NORM_W   = 16;
	localparam int SUM_W    = 24;
	localparam int CNT_W    = 8;

	localparam logic signed [SUM_W:0] SUM_MAX = 25'sd8388607;
	localparam logic signed [SUM_W:0] SUM_MIN = -25'sd8388608;
	localparam logic [CNT_W-1:0]      CNT_SAT = 8'd255;
	localparam logic [16:0]           ONE_Q14 = 17'd16384;

	typedef struct packed {
		logic [1:0]              func;
		logic [IDX_IN_W-1:0]     index_a;
		logic [IDX_IN_W-1:0]     index_b;
		logic [IDX_IN_W-1:0]     index_c;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
	} in_beat_t;

	typedef struct packed {
		logic                     kind;
		logic signed [NORM_W-1:0] norm_x;
		logic signed [NORM_W-1:0] norm_y;
		logic signed [NORM_W-1:0] norm_z;
		logic                     degenerate;
		logic [CNT_W-1:0]         share_count;
	} out_beat_t;

endpackage

### sv/mvn_front.sv
module mvn_front #(
	parameter int MAX_VERTICES = 1024,
	parameter int COORD_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  mvn_pkg::in_beat_t                        in_data,
	input  logic                                     clearing,
	output logic                                     q_valid,
	output logic [1:0]                               q_op,
	output logic [$clog2(MAX_VERTICES)-1:0]          q_ia,
	output logic [$clog2(MAX_VERTICES)-1:0]          q_ib,
	output logic [$clog2(MAX_VERTICES)-1:0]          q_ic,
	output logic [COORD_BITS-1:0]                    q_px,
	output logic [COORD_BITS-1:0]                    q_py,
	output logic [COORD_BITS-1:0]                    q_pz,
	input  logic                                     q_pop
);
	import mvn_pkg::*;

	localparam int IDX_W  = $clog2(MAX_VERTICES);
	localparam int WRAP_W = 20;

	typedef struct packed {
		logic [1:0]            op;
		logic [IDX_W-1:0]      ia;
		logic [IDX_W-1:0]      ib;
		logic [IDX_W-1:0]      ic;
		logic [COORD_BITS-1:0] px;
		logic [COORD_BITS-1:0] py;
		logic [COORD_BITS-1:0] pz;
	} qent_t;

	// Index modulo the vertex count, by restoring subtraction of shifted multiples.
	function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_IN_W-1:0] v);
		logic [WRAP_W-1:0] r;
		r = WRAP_W'(v);
		if (MAX_VERTICES < 1024) begin
			for (int b = IDX_IN_W - 1; b >= 0; b--) begin
				if (r >= (WRAP_W'(MAX_VERTICES) << b))
					r = r - (WRAP_W'(MAX_VERTICES) << b);
			end
		end
		return r[IDX_W-1:0];
	endfunction

	qent_t             ent_q [2];
	qent_t             new_ent;
	logic              wp_q, rp_q;
	logic [1:0]        cnt_q;
	logic              push;
	logic [WRAP_W-1:0] ext_x, ext_y, ext_z;

	assign in_stall = clearing || (cnt_q == 2'd2);
	assign push = in_valid && !in_stall &&
		(in_data.func inside {FUNC_WRITE, FUNC_TRI, FUNC_READ});

	// Coordinates above the field width come in as zero bits.
	assign ext_x = {4'b0000, in_data.pos_x};
	assign ext_y = {4'b0000, in_data.pos_y};
	assign ext_z = {4'b0000, in_data.pos_z};

	always_comb begin
		new_ent.op = in_data.func;
		new_ent.ia = wrap_idx(in_data.index_a);
		new_ent.ib = wrap_idx(in_data.index_b);
		new_ent.ic = wrap_idx(in_data.index_c);
		new_ent.px = ext_x[COORD_BITS-1:0];
		new_ent.py = ext_y[COORD_BITS-1:0];
		new_ent.pz = ext_z[COORD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (q_pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= new_ent;
	end

	assign q_valid = (cnt_q != 2'd0);
	assign q_op    = ent_q[rp_q].op;
	assign q_ia    = ent_q[rp_q].ia;
	assign q_ib    = ent_q[rp_q].ib;
	assign q_ic    = ent_q[rp_q].ic;
	assign q_px    = ent_q[rp_q].px;
	assign q_py    = ent_q[rp_q].py;
	assign q_pz    = ent_q[rp_q].pz;

endmodule

### sv/mvn_norm.sv
module mvn_norm #(
	parameter int MW = 35
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [MW-1:0] vx,
	input  logic signed [MW-1:0] vy,
	input  logic signed [MW-1:0] vz,
	output logic                 done,
	output logic signed [15:0]   nx,
	output logic signed [15:0]   ny,
	output logic signed [15:0]   nz,
	output logic                 deg
);
	import mvn_pkg::*;

	localparam int XW = (MW > 31) ? MW : 31;

	localparam logic [2:0] N_IDLE  = 3'd0;
	localparam logic [2:0] N_SHIFT = 3'd1;
	localparam logic [2:0] N_SQ    = 3'd2;
	localparam logic [2:0] N_SQRT  = 3'd3;
	localparam logic [2:0] N_DINIT = 3'd4;
	localparam logic [2:0] N_DIV   = 3'd5;

	logic [2:0]         state_q;
	logic [XW-1:0]      m_q [3];
	logic [2:0]         neg_q;
	logic [1:0]         k_q;
	logic [59:0]        sq_s1;
	logic [61:0]        s_q;
	logic [61:0]        root_q;
	logic [60:0]        bit_q;
	logic [47:0]        rem_q;
	logic [48:0]        dsh_q;
	logic [16:0]        quo_q;
	logic [4:0]         dcnt_q;
	logic signed [15:0] n_q [3];
	logic               deg_q, done_q;

	logic [MW-1:0]  ax, ay, az;
	logic [XW-1:0]  orv;
	logic [62:0]    sqrt_t;
	logic           div_ge;
	logic [16:0]    quo_n;
	logic [15:0]    quo_c;

	assign ax = vx[MW-1] ? MW'(-vx) : vx;
	assign ay = vy[MW-1] ? MW'(-vy) : vy;
	assign az = vz[MW-1] ? MW'(-vz) : vz;

	// The OR of the magnitudes has its leading one where the largest one has it.
	assign orv    = m_q[0] | m_q[1] | m_q[2];
	assign sqrt_t = 63'(root_q) + 63'(bit_q);
	assign div_ge = (49'(rem_q) >= dsh_q);
	assign quo_n  = {quo_q[15:0], div_ge};
	assign quo_c  = (quo_n > ONE_Q14) ? ONE_Q14[15:0] : quo_n[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			done_q  <= 1'b0;
			k_q     <= 2'd0;
			dcnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				N_IDLE: begin
					if (start) begin
						if ((ax | ay | az) == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= N_SHIFT;
						end
					end
				end
				N_SHIFT: begin
					if (!(|orv[XW-1:30]) && orv[29]) begin
						state_q <= N_SQ;
						k_q     <= 2'd0;
					end
				end
				N_SQ: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3)
						state_q <= N_SQRT;
				end
				N_SQRT: begin
					if (bit_q[0]) begin
						state_q <= N_DINIT;
						k_q     <= 2'd0;
					end
				end
				N_DINIT: begin
					state_q <= N_DIV;
					dcnt_q  <= 5'd0;
				end
				N_DIV: begin
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'd16) begin
						if (k_q == 2'd2) begin
							state_q <= N_IDLE;
							done_q  <= 1'b1;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= N_DINIT;
						end
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					m_q[0] <= XW'(ax);
					m_q[1] <= XW'(ay);
					m_q[2] <= XW'(az);
					neg_q  <= {vz[MW-1], vy[MW-1], vx[MW-1]};
					if ((ax | ay | az) == '0) begin
						n_q[0] <= '0;
						n_q[1] <= '0;
						n_q[2] <= '0;
						deg_q  <= 1'b1;
					end else begin
						deg_q <= 1'b0;
					end
				end
			end
			N_SHIFT: begin
				if (|orv[XW-1:30]) begin
					for (int i = 0; i < 3; i++)
						m_q[i] <= m_q[i] >> 1;
				end else if (!orv[29]) begin
					for (int i = 0; i < 3; i++)
						m_q[i] <= m_q[i] << 1;
				end
				s_q <= '0;
			end
			N_SQ: begin
				if (k_q != 2'd3)
					sq_s1 <= 60'(m_q[k_q][29:0]) * 60'(m_q[k_q][29:0]);
				if (k_q != 2'd0)
					s_q <= s_q + 62'(sq_s1);
				root_q <= '0;
				bit_q  <= 61'(1) << 60;
			end
			N_SQRT: begin
				if (63'(s_q) >= sqrt_t) begin
					s_q    <= s_q - sqrt_t[61:0];
					root_q <= (root_q >> 1) + 62'(bit_q);
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			N_DINIT: begin
				rem_q <= {3'b000, m_q[k_q][29:0], 15'd0} + 48'(root_q[31:0]);
				dsh_q <= {root_q[31:0], 17'd0};
				quo_q <= '0;
			end
			N_DIV: begin
				if (div_ge)
					rem_q <= 48'(49'(rem_q) - dsh_q);
				dsh_q <= dsh_q >> 1;
				quo_q <= quo_n;
				if (dcnt_q == 5'd16)
					n_q[k_q] <= neg_q[k_q] ? -$signed(quo_c) : $signed(quo_c);
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign nx   = n_q[0];
	assign ny   = n_q[1];
	assign nz   = n_q[2];
	assign deg  = deg_q;

endmodule

### sv/mvn_back.sv
module mvn_back #(
	parameter int MAX_VERTICES = 1024,
	parameter int COORD_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	output logic                              clearing,
	input  logic                              q_valid,
	input  logic [1:0]                        q_op,
	input  logic [$clog2(MAX_VERTICES)-1:0]   q_ia,
	input  logic [$clog2(MAX_VERTICES)-1:0]   q_ib,
	input  logic [$clog2(MAX_VERTICES)-1:0]   q_ic,
	input  logic [COORD_BITS-1:0]             q_px,
	input  logic [COORD_BITS-1:0]             q_py,
	input  logic [COORD_BITS-1:0]             q_pz,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output mvn_pkg::out_beat_t                out_data
);
	import mvn_pkg::*;

	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int C     = COORD_BITS;
	localparam int DW    = C + 1;
	localparam int PW    = 2 * DW;
	localparam int CW    = PW + 1;
	localparam int MW    = (CW > SUM_W) ? CW : SUM_W;
	localparam int ACC_W = 3 * SUM_W + CNT_W;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RV0   = 4'd2;
	localparam logic [3:0] S_RV1   = 4'd3;
	localparam logic [3:0] S_RV2   = 4'd4;
	localparam logic [3:0] S_RV3   = 4'd5;
	localparam logic [3:0] S_MUL   = 4'd6;
	localparam logic [3:0] S_NST   = 4'd7;
	localparam logic [3:0] S_NWAIT = 4'd8;
	localparam logic [3:0] S_EMIT  = 4'd9;
	localparam logic [3:0] S_UR    = 4'd10;
	localparam logic [3:0] S_UW    = 4'd11;
	localparam logic [3:0] S_RS0   = 4'd12;

	logic [3:0]        state_q;
	logic [IDX_W-1:0]  clr_q;
	logic [1:0]        op_q;
	logic [IDX_W-1:0]  ia_q, ib_q, ic_q;
	logic [2:0]        mstep_q, pstep_s1;
	logic [1:0]        ustep_q;
	logic [CNT_W-1:0]  rcnt_q;

	logic [3*C-1:0]    vmem [MAX_VERTICES];
	logic [3*C-1:0]    vrd_q;
	logic [IDX_W-1:0]  vraddr;
	logic [3*C-1:0]    pa_q, pb_q, pc_q;

	logic [ACC_W-1:0]  amem [MAX_VERTICES];
	logic [ACC_W-1:0]  ard_q;
	logic [IDX_W-1:0]  araddr, awaddr;
	logic [ACC_W-1:0]  awdata;
	logic              awe;

	logic signed [DW-1:0] e1x, e1y, e1z, e2x, e2y, e2z, ma, mb;
	logic signed [PW-1:0] prod_s1;
	logic signed [CW-1:0] vx_q, vy_q, vz_q;

	logic signed [MW-1:0] nin_x, nin_y, nin_z;
	logic                 n_start, n_done, n_deg;
	logic signed [15:0]   n_x, n_y, n_z;

	logic                 slot_free;
	logic [IDX_W-1:0]     corner;
	logic signed [SUM_W:0] tx, ty, tz;
	logic [SUM_W-1:0]     ux, uy, uz;
	logic [CNT_W-1:0]     ucnt;

	function automatic logic [SUM_W-1:0] sat24(input logic signed [SUM_W:0] t);
		if (t > SUM_MAX)
			return SUM_MAX[SUM_W-1:0];
		if (t < SUM_MIN)
			return SUM_MIN[SUM_W-1:0];
		return t[SUM_W-1:0];
	endfunction

	assign clearing  = (state_q == S_CLR);
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign slot_free = !out_valid || !out_stall;

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			mstep_q   <= 3'd0;
			ustep_q   <= 2'd0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == S_EMIT && slot_free)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(MAX_VERTICES - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_valid) begin
						case (q_op)
							FUNC_TRI:  state_q <= S_RV0;
							FUNC_READ: state_q <= S_RS0;
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_RV0: state_q <= S_RV1;
				S_RV1: state_q <= S_RV2;
				S_RV2: state_q <= S_RV3;
				S_RV3: begin
					state_q <= S_MUL;
					mstep_q <= 3'd0;
				end
				S_MUL: begin
					mstep_q <= mstep_q + 3'd1;
					if (mstep_q == 3'd6)
						state_q <= S_NST;
				end
				S_RS0:  state_q <= S_NST;
				S_NST:  state_q <= S_NWAIT;
				S_NWAIT: begin
					if (n_done)
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						ustep_q   <= 2'd0;
						state_q   <= (op_q == FUNC_TRI) ? S_UR : S_IDLE;
					end
				end
				S_UR: state_q <= S_UW;
				S_UW: begin
					ustep_q <= ustep_q + 2'd1;
					state_q <= (ustep_q == 2'd2) ? S_IDLE : S_UR;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q <= q_op;
			ia_q <= q_ia;
			ib_q <= q_ib;
			ic_q <= q_ic;
		end
		if (state_q == S_RV1)
			pa_q <= vrd_q;
		if (state_q == S_RV2)
			pb_q <= vrd_q;
		if (state_q == S_RV3) begin
			pc_q <= vrd_q;
			vx_q <= '0;
			vy_q <= '0;
			vz_q <= '0;
		end
		if (state_q == S_MUL) begin
			prod_s1  <= ma * mb;
			pstep_s1 <= mstep_q;
			if (mstep_q != 3'd0) begin
				case (pstep_s1)
					3'd0:    vx_q <= vx_q + CW'(prod_s1);
					3'd1:    vx_q <= vx_q - CW'(prod_s1);
					3'd2:    vy_q <= vy_q + CW'(prod_s1);
					3'd3:    vy_q <= vy_q - CW'(prod_s1);
					3'd4:    vz_q <= vz_q + CW'(prod_s1);
					default: vz_q <= vz_q - CW'(prod_s1);
				endcase
			end
		end
		if (state_q == S_NST)
			rcnt_q <= ard_q[CNT_W-1:0];
		if (state_q == S_EMIT && slot_free) begin
			out_data.kind        <= (op_q == FUNC_TRI) ? KIND_FACE : KIND_VERTEX;
			out_data.norm_x      <= n_x;
			out_data.norm_y      <= n_y;
			out_data.norm_z      <= n_z;
			out_data.degenerate  <= n_deg;
			out_data.share_count <= (op_q == FUNC_TRI) ? '0 : rcnt_q;
		end
	end

	// Vertex position memory.
	always_comb begin
		case (state_q)
			S_RV0:   vraddr = ia_q;
			S_RV1:   vraddr = ib_q;
			default: vraddr = ic_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_op == FUNC_WRITE)
			vmem[q_ia] <= {q_px, q_py, q_pz};
		vrd_q <= vmem[vraddr];
	end

	// Edge vectors and multiplier operand selection.
	assign e1x = $signed({pb_q[3*C-1], pb_q[3*C-1:2*C]}) - $signed({pa_q[3*C-1], pa_q[3*C-1:2*C]});
	assign e1y = $signed({pb_q[2*C-1], pb_q[2*C-1:C]}) - $signed({pa_q[2*C-1], pa_q[2*C-1:C]});
	assign e1z = $signed({pb_q[C-1], pb_q[C-1:0]}) - $signed({pa_q[C-1], pa_q[C-1:0]});
	assign e2x = $signed({pc_q[3*C-1], pc_q[3*C-1:2*C]}) - $signed({pa_q[3*C-1], pa_q[3*C-1:2*C]});
	assign e2y = $signed({pc_q[2*C-1], pc_q[2*C-1:C]}) - $signed({pa_q[2*C-1], pa_q[2*C-1:C]});
	assign e2z = $signed({pc_q[C-1], pc_q[C-1:0]}) - $signed({pa_q[C-1], pa_q[C-1:0]});

	always_comb begin
		case (mstep_q)
			3'd0:    begin ma = e1y; mb = e2z; end
			3'd1:    begin ma = e1z; mb = e2y; end
			3'd2:    begin ma = e1z; mb = e2x; end
			3'd3:    begin ma = e1x; mb = e2z; end
			3'd4:    begin ma = e1x; mb = e2y; end
			default: begin ma = e1y; mb = e2x; end
		endcase
	end

	// Sum and count memory.
	always_comb begin
		case (ustep_q)
			2'd0:    corner = ia_q;
			2'd1:    corner = ib_q;
			default: corner = ic_q;
		endcase
	end

	assign araddr = (state_q == S_UR) ? corner : ia_q;

	assign tx   = (SUM_W + 1)'($signed(ard_q[ACC_W-1:ACC_W-SUM_W])) + (SUM_W + 1)'(n_x);
	assign ty   = (SUM_W + 1)'($signed(ard_q[ACC_W-SUM_W-1:ACC_W-2*SUM_W])) + (SUM_W + 1)'(n_y);
	assign tz   = (SUM_W + 1)'($signed(ard_q[CNT_W+SUM_W-1:CNT_W])) + (SUM_W + 1)'(n_z);
	assign ux   = sat24(tx);
	assign uy   = sat24(ty);
	assign uz   = sat24(tz);
	assign ucnt = (ard_q[CNT_W-1:0] == CNT_SAT) ? CNT_SAT : ard_q[CNT_W-1:0] + CNT_W'(1);

	always_comb begin
		if (state_q == S_CLR) begin
			awe    = 1'b1;
			awaddr = clr_q;
			awdata = '0;
		end else begin
			awe    = (state_q == S_UW);
			awaddr = corner;
			awdata = {ux, uy, uz, ucnt};
		end
	end

	always_ff @(posedge clk) begin
		if (awe)
			amem[awaddr] <= awdata;
		ard_q <= amem[araddr];
	end

	// Normalizer input: cross product for a triangle, stored sums for a read.
	assign n_start = (state_q == S_NST);
	assign nin_x = (op_q == FUNC_TRI) ? MW'(vx_q) : MW'($signed(ard_q[ACC_W-1:ACC_W-SUM_W]));
	assign nin_y = (op_q == FUNC_TRI) ? MW'(vy_q)
		: MW'($signed(ard_q[ACC_W-SUM_W-1:ACC_W-2*SUM_W]));
	assign nin_z = (op_q == FUNC_TRI) ? MW'(vz_q) : MW'($signed(ard_q[CNT_W+SUM_W-1:CNT_W]));

	mvn_norm #(
		.MW(MW)
	) u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (n_start),
		.vx     (nin_x),
		.vy     (nin_y),
		.vz     (nin_z),
		.done   (n_done),
		.nx     (n_x),
		.ny     (n_y),
		.nz     (n_z),
		.deg    (n_deg)
	);

endmodule

### sv/mesh_vertex_normal_engine_unit.sv
// Vertex writes retire as soon as they reach the back end of the queue.
// Triangles and reads are handled one at a time and wait on output stalls; the
// shared normalizer (shift to range, 31-step square root, three 17-step divisions)
// takes most of their time. A zero vector skips those normalizer steps.
// After reset the sum and count memory is cleared one entry at a time, and
// no beat is accepted until that pass ends. Vertex positions are not cleared.
module mesh_vertex_normal_engine_unit #(
	parameter int MAX_VERTICES = 1024,
	parameter int COORD_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mvn_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output mvn_pkg::out_beat_t out_data
);
	import mvn_pkg::*;

	localparam int IDX_W = $clog2(MAX_VERTICES);

	logic                  clearing;
	logic                  q_valid, q_pop;
	logic [1:0]            q_op;
	logic [IDX_W-1:0]      q_ia, q_ib, q_ic;
	logic [COORD_BITS-1:0] q_px, q_py, q_pz;

	mvn_front #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_BITS   (COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.clearing (clearing),
		.q_valid  (q_valid),
		.q_op     (q_op),
		.q_ia     (q_ia),
		.q_ib     (q_ib),
		.q_ic     (q_ic),
		.q_px     (q_px),
		.q_py     (q_py),
		.q_pz     (q_pz),
		.q_pop    (q_pop)
	);

	mvn_back #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_BITS   (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.q_valid   (q_valid),
		.q_op      (q_op),
		.q_ia      (q_ia),
		.q_ib      (q_ib),
		.q_ic      (q_ic),
		.q_px      (q_px),
		.q_py      (q_py),
		.q_pz      (q_pz),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
